@@ design/clsg_pkg.sv @@
package clsg_pkg;

   localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
   localparam logic [9:0]  US_PER_MS = 10'd1000;

   localparam logic [4:0] OP_HELLO = 5'd0;
   localparam logic [4:0] OP_TIMESYNC = 5'd1;
   localparam logic [4:0] OP_ESTOP = 5'd2;
   localparam logic [4:0] OP_HOLD = 5'd3;
   localparam logic [4:0] OP_ACQUIRE = 5'd4;
   localparam logic [4:0] OP_RELEASE = 5'd5;
   localparam logic [4:0] OP_SETMODE = 5'd6;
   localparam logic [4:0] OP_HEARTBEAT = 5'd7;
   localparam logic [4:0] OP_KEEPALIVE = 5'd8;
   localparam logic [4:0] OP_TARGET = 5'd9;
   localparam logic [4:0] OP_DIAG = 5'd11;
   localparam logic [4:0] OP_TICK = 5'd13;
   localparam logic [4:0] OP_SETFAULT = 5'd14;
   localparam logic [4:0] OP_SAFETYHOLD = 5'd15;
   localparam logic [4:0] OP_LOCALCLEAR = 5'd16;

   localparam logic [2:0] KIND_ACK = 3'd0;
   localparam logic [2:0] KIND_NACK = 3'd1;
   localparam logic [2:0] KIND_HELLO = 3'd2;
   localparam logic [2:0] KIND_TSYNC = 3'd3;
   localparam logic [2:0] KIND_NONE = 3'd4;

   localparam logic [3:0] RC_OK = 4'd0;
   localparam logic [3:0] RC_BADSESSION = 4'd1;
   localparam logic [3:0] RC_BADLENGTH = 4'd2;
   localparam logic [3:0] RC_BADCONFIG = 4'd3;
   localparam logic [3:0] RC_FAULT = 4'd4;
   localparam logic [3:0] RC_BADMODE = 4'd5;
   localparam logic [3:0] RC_CONFLICT = 4'd6;
   localparam logic [3:0] RC_RANGE = 4'd7;
   localparam logic [3:0] RC_BADSEQ = 4'd8;
   localparam logic [3:0] RC_NOLEASE = 4'd9;
   localparam logic [3:0] RC_EXPIRED = 4'd10;
   localparam logic [3:0] RC_NONFINITE = 4'd11;
   localparam logic [3:0] RC_UNSUPPORTED = 4'd12;

   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_TELEOP = 2'd1;
   localparam logic [1:0] MODE_POLICY = 2'd2;
   localparam logic [1:0] MODE_FAULT = 2'd3;

   localparam logic [15:0] HOLD_OPERATOR = 16'h0001;
   localparam logic [15:0] HOLD_LEASE_TO = 16'h0002;
   localparam logic [15:0] HOLD_TARGET_TO = 16'h0004;
   localparam logic [15:0] FAULT_ESTOP = 16'h0001;

   localparam logic [1:0] ADDR_MAX_LEASE = 2'd0;
   localparam logic [1:0] ADDR_MAX_TTL = 2'd1;
   localparam logic [1:0] ADDR_VERIFIED = 2'd2;

   localparam logic [31:0] RESET_MAX_LEASE = 32'd1000;
   localparam logic [31:0] RESET_MAX_TTL = 32'd200;

   typedef struct packed {
      logic [4:0]  op;
      logic [63:0] now_us;
      logic [31:0] sess;
      logic [31:0] seq;
      logic        length_ok;
      logic [31:0] arg;
      logic [31:0] tick_token;
      logic [31:0] action_seq;
      logic        hash_ok;
      logic [1:0]  target_verdict;
      logic        feedback_ready;
      logic        hw_is_safe;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  result_code;
      logic        detail;
      logic [31:0] echo_sess;
      logic [31:0] echo_seq;
      logic        estop_req;
      logic        went_to_hold;
      logic        new_target;
      logic        diag_req;
      logic        local_flag;
      logic [1:0]  mode_now;
      logic [15:0] hold_reasons_now;
   } rsp_type;

   typedef struct packed {
      logic [31:0] lease_limit_ms;
      logic [31:0] ttl_limit_ms;
      logic        params_verified;
   } cfg_type;

   // wrap-aware "cand is newer than prev"
   function automatic logic newer(input logic [31:0] cand, input logic [31:0] prev);
      logic [31:0] d;
      d = cand - prev;
      return (d != 32'd0) && (d < HALF_RANGE);
   endfunction

   // ms times 1000 fits in 42 bits; the sum wraps at 64 bits
   function automatic logic [63:0] deadline_from(input logic [63:0] now,
                                                 input logic [31:0] ms);
      logic [41:0] span;
      span = 42'(ms) * 42'(US_PER_MS);
      return now + 64'(span);
   endfunction

endpackage

@@ design/control_lease_session_guard_unit.sv @@
// An accepted item's result goes to the result register, or to the one-entry
// skid behind it while the output is stalled. Throughput: one item per cycle
// while the skid is empty; the decision is a single pass of logic over the
// session registers. Reset (synchronous, active high) clears the session state,
// sets the mode to hold and loads the register reset values.
module control_lease_session_guard_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  clsg_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output clsg_pkg::rsp_type    rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import clsg_pkg::*;

   cfg_type cfg;

   clsg_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready), .cfg(cfg)
   );

   // session state
   logic hello_valid_ff, hello_valid_in;
   logic [31:0] hello_sess_ff, hello_sess_in, hello_seq_ff, hello_seq_in;
   logic lease_on_ff, lease_on_in;
   logic [31:0] owner_sess_ff, owner_sess_in;
   logic [31:0] cmd_mark_ff, cmd_mark_in, target_mark_ff, target_mark_in;
   logic [31:0] tick_mark_ff, tick_mark_in, lease_len_ff, lease_len_in;
   logic [63:0] lease_dl_ff, lease_dl_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] hold_bits_ff, hold_bits_in, fault_ff, fault_in;
   logic target_valid_ff, target_valid_in;
   logic [31:0] target_seq_ff, target_seq_in, target_ttl_ff, target_ttl_in;
   logic [63:0] target_dl_ff, target_dl_in;

   // output register plus skid
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff, res;
   logic    accept;

   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // decision logic for one item
   always_comb begin
      logic [4:0] op;
      logic [63:0] now;
      logic same;
      logic [1:0] hmode;
      op = req_data.op;
      now = req_data.now_us;
      hmode = (fault_ff == 16'd0) ? MODE_HOLD : MODE_FAULT;

      hello_valid_in = hello_valid_ff; hello_sess_in = hello_sess_ff;
      hello_seq_in = hello_seq_ff; lease_on_in = lease_on_ff;
      owner_sess_in = owner_sess_ff; cmd_mark_in = cmd_mark_ff;
      target_mark_in = target_mark_ff; tick_mark_in = tick_mark_ff;
      lease_len_in = lease_len_ff; lease_dl_in = lease_dl_ff;
      mode_in = mode_ff; hold_bits_in = hold_bits_ff; fault_in = fault_ff;
      target_valid_in = target_valid_ff; target_seq_in = target_seq_ff;
      target_ttl_in = target_ttl_ff; target_dl_in = target_dl_ff;

      res = '0;
      res.kind = KIND_ACK;
      res.result_code = RC_OK;
      res.echo_sess = req_data.sess;
      res.echo_seq = req_data.seq;
      same = lease_on_ff && (req_data.sess == owner_sess_ff);

      if (op inside {[OP_TICK:OP_LOCALCLEAR]}) begin
         res.kind = KIND_NONE;
         res.echo_sess = 32'd0;
         res.echo_seq = 32'd0;
         case (op)
            OP_TICK: begin
               if (lease_on_ff && now >= lease_dl_ff) begin
                  mode_in = hmode; hold_bits_in = hold_bits_ff | HOLD_LEASE_TO;
                  target_valid_in = 1'b0; target_seq_in = '0;
                  target_ttl_in = '0; target_dl_in = '0;
                  lease_on_in = 1'b0; res.local_flag = 1'b1;
               end else if (target_valid_ff && now >= target_dl_ff) begin
                  mode_in = hmode; hold_bits_in = hold_bits_ff | HOLD_TARGET_TO;
                  target_valid_in = 1'b0; target_seq_in = '0;
                  target_ttl_in = '0; target_dl_in = '0;
                  res.local_flag = 1'b1;
               end
            end
            OP_SETFAULT: begin
               fault_in = fault_ff | req_data.arg[15:0];
               mode_in = MODE_FAULT; lease_on_in = 1'b0;
               target_valid_in = 1'b0; target_seq_in = '0;
               target_ttl_in = '0; target_dl_in = '0;
            end
            OP_SAFETYHOLD: begin
               if (req_data.arg[15:0] != 16'd0 && fault_ff == 16'd0) begin
                  mode_in = hmode; hold_bits_in = hold_bits_ff | req_data.arg[15:0];
                  target_valid_in = 1'b0; target_seq_in = '0;
                  target_ttl_in = '0; target_dl_in = '0;
               end
            end
            default: begin
               if (req_data.hw_is_safe) begin
                  fault_in = '0; mode_in = MODE_HOLD; hold_bits_in = '0;
                  target_valid_in = 1'b0; target_seq_in = '0;
                  target_ttl_in = '0; target_dl_in = '0;
                  res.local_flag = 1'b1;
               end
            end
         endcase
      end else if (op == OP_HELLO) begin
         if (req_data.sess == 32'd0) res.result_code = RC_BADSESSION;
         else if (!req_data.length_ok) res.result_code = RC_BADLENGTH;
         else if (!req_data.hash_ok) begin
            hello_valid_in = 1'b0; res.result_code = RC_BADCONFIG;
         end else begin
            if (!hello_valid_ff || req_data.sess != hello_sess_ff) begin
               lease_on_in = 1'b0;
               target_valid_in = 1'b0; target_seq_in = '0;
               target_ttl_in = '0; target_dl_in = '0;
               mode_in = hmode;
            end
            hello_valid_in = 1'b1; hello_sess_in = req_data.sess;
            hello_seq_in = req_data.seq; res.kind = KIND_HELLO;
         end
      end else if (op == OP_TIMESYNC) begin
         if (!hello_valid_ff || req_data.sess != hello_sess_ff)
            res.result_code = RC_BADSESSION;
         else if (!req_data.length_ok) res.result_code = RC_BADLENGTH;
         else res.kind = KIND_TSYNC;
      end else if (op == OP_ESTOP) begin
         fault_in = fault_ff | FAULT_ESTOP; mode_in = MODE_FAULT; lease_on_in = 1'b0;
         target_valid_in = 1'b0; target_seq_in = '0;
         target_ttl_in = '0; target_dl_in = '0;
         res.estop_req = 1'b1; res.went_to_hold = 1'b1;
      end else if (op == OP_HOLD) begin
         mode_in = hmode; hold_bits_in = hold_bits_ff | HOLD_OPERATOR;
         target_valid_in = 1'b0; target_seq_in = '0;
         target_ttl_in = '0; target_dl_in = '0;
         res.went_to_hold = 1'b1;
      end else if (op == OP_ACQUIRE) begin
         if (!hello_valid_ff || req_data.sess != hello_sess_ff)
            res.result_code = RC_BADCONFIG;
         else if (!req_data.length_ok) res.result_code = RC_BADLENGTH;
         else if (!cfg.params_verified) res.result_code = RC_BADCONFIG;
         else if (fault_ff != 16'd0) res.result_code = RC_FAULT;
         else if (!req_data.feedback_ready) begin
            res.result_code = RC_BADMODE; res.detail = 1'b1;
         end else if (lease_on_ff && !same) res.result_code = RC_CONFLICT;
         else if (req_data.arg == 32'd0 || req_data.arg > cfg.lease_limit_ms)
            res.result_code = RC_RANGE;
         else if (!newer(req_data.seq, same ? cmd_mark_ff : hello_seq_ff))
            res.result_code = RC_BADSEQ;
         else begin
            owner_sess_in = req_data.sess; cmd_mark_in = req_data.seq;
            if (!same) begin
               target_mark_in = req_data.seq; tick_mark_in = '0;
            end
            lease_len_in = req_data.arg; lease_on_in = 1'b1;
            mode_in = MODE_HOLD; hold_bits_in = '0;
            target_valid_in = 1'b0; target_seq_in = '0;
            target_ttl_in = '0; target_dl_in = '0;
            lease_dl_in = deadline_from(now, req_data.arg);
         end
      end else if (!lease_on_ff) res.result_code = RC_NOLEASE;
      else if (req_data.sess != owner_sess_ff) res.result_code = RC_BADSESSION;
      else if (op == OP_TARGET ? !newer(req_data.seq, target_mark_ff)
                               : !newer(req_data.seq, cmd_mark_ff))
         res.result_code = RC_BADSEQ;
      else begin
         // sequence accepted: advance watermarks
         if (op == OP_TARGET) begin
            target_mark_in = req_data.seq;
            if (newer(req_data.seq, cmd_mark_ff)) cmd_mark_in = req_data.seq;
         end else cmd_mark_in = req_data.seq;
         if (!req_data.length_ok && (op inside {[OP_RELEASE:OP_TARGET], OP_DIAG}))
            res.result_code = RC_BADLENGTH;
         else begin
            case (op)
               OP_RELEASE: begin
                  mode_in = hmode; hold_bits_in = hold_bits_ff | HOLD_OPERATOR;
                  target_valid_in = 1'b0; target_seq_in = '0;
                  target_ttl_in = '0; target_dl_in = '0;
                  lease_on_in = 1'b0; res.went_to_hold = 1'b1;
               end
               OP_SETMODE: begin
                  if (req_data.arg > 32'(MODE_POLICY)) res.result_code = RC_BADMODE;
                  else if (fault_ff != 16'd0) res.result_code = RC_FAULT;
                  else begin
                     target_valid_in = 1'b0; target_seq_in = '0;
                     target_ttl_in = '0; target_dl_in = '0;
                     mode_in = req_data.arg[1:0];
                     hold_bits_in = (req_data.arg[1:0] == MODE_HOLD) ? HOLD_OPERATOR
                                                                      : 16'd0;
                     res.went_to_hold = (req_data.arg[1:0] == MODE_HOLD);
                  end
               end
               OP_HEARTBEAT: lease_dl_in = deadline_from(now, lease_len_ff);
               OP_KEEPALIVE: begin
                  if (mode_ff != MODE_TELEOP && mode_ff != MODE_POLICY)
                     res.result_code = RC_BADMODE;
                  else if (!target_valid_ff || req_data.action_seq != target_seq_ff)
                     res.result_code = RC_BADSEQ;
                  else if (now >= target_dl_ff) begin
                     mode_in = hmode; hold_bits_in = hold_bits_ff | HOLD_TARGET_TO;
                     target_valid_in = 1'b0; target_seq_in = '0;
                     target_ttl_in = '0; target_dl_in = '0;
                     res.result_code = RC_EXPIRED;
                  end else if (!newer(req_data.tick_token, tick_mark_ff))
                     res.result_code = RC_BADSEQ;
                  else begin
                     target_dl_in = deadline_from(now, target_ttl_ff);
                     tick_mark_in = req_data.tick_token;
                  end
               end
               OP_TARGET: begin
                  if (mode_ff != MODE_TELEOP && mode_ff != MODE_POLICY)
                     res.result_code = RC_BADMODE;
                  else if (req_data.arg == 32'd0 || req_data.arg > cfg.ttl_limit_ms)
                     res.result_code = RC_EXPIRED;
                  else if (req_data.target_verdict == 2'd1) res.result_code = RC_NONFINITE;
                  else if (req_data.target_verdict != 2'd0) res.result_code = RC_RANGE;
                  else if (!newer(req_data.tick_token, tick_mark_ff))
                     res.result_code = RC_BADSEQ;
                  else begin
                     target_seq_in = req_data.seq;
                     target_dl_in = deadline_from(now, req_data.arg);
                     target_ttl_in = req_data.arg; target_valid_in = 1'b1;
                     tick_mark_in = req_data.tick_token; res.new_target = 1'b1;
                  end
               end
               OP_DIAG: res.diag_req = 1'b1;
               default: res.result_code = RC_UNSUPPORTED;
            endcase
         end
      end
      if (res.result_code != RC_OK) res.kind = KIND_NACK;
      res.mode_now = mode_in;
      res.hold_reasons_now = hold_bits_in;
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         hello_valid_ff <= 1'b0; hello_sess_ff <= '0; hello_seq_ff <= '0;
         lease_on_ff <= 1'b0; owner_sess_ff <= '0; cmd_mark_ff <= '0;
         target_mark_ff <= '0; tick_mark_ff <= '0; lease_len_ff <= '0;
         lease_dl_ff <= '0; mode_ff <= MODE_HOLD; hold_bits_ff <= '0; fault_ff <= '0;
         target_valid_ff <= 1'b0; target_seq_ff <= '0; target_ttl_ff <= '0;
         target_dl_ff <= '0;
      end else if (accept) begin
         hello_valid_ff <= hello_valid_in; hello_sess_ff <= hello_sess_in;
         hello_seq_ff <= hello_seq_in; lease_on_ff <= lease_on_in;
         owner_sess_ff <= owner_sess_in; cmd_mark_ff <= cmd_mark_in;
         target_mark_ff <= target_mark_in; tick_mark_ff <= tick_mark_in;
         lease_len_ff <= lease_len_in; lease_dl_ff <= lease_dl_in;
         mode_ff <= mode_in; hold_bits_ff <= hold_bits_in; fault_ff <= fault_in;
         target_valid_ff <= target_valid_in; target_seq_ff <= target_seq_in;
         target_ttl_ff <= target_ttl_in; target_dl_ff <= target_dl_in;
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || !rsp_stall) begin
            if (skid_valid_ff) begin
               out_valid_ff <= 1'b1; skid_valid_ff <= 1'b0;
            end else out_valid_ff <= accept;
         end else if (accept) skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) out_ff <= skid_ff;
         else if (accept) out_ff <= res;
      end else if (accept) skid_ff <= res;
   end

endmodule

@@ design/clsg_csr.sv @@
module clsg_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output clsg_pkg::cfg_type     cfg
);
   import clsg_pkg::*;

   cfg_type cfg_ff;
   logic    wr;
   logic [1:0] reg_sel;

   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lease_limit_ms <= RESET_MAX_LEASE;
         cfg_ff.ttl_limit_ms <= RESET_MAX_TTL;
         cfg_ff.params_verified <= 1'b0;
      end else if (wr) begin
         case (reg_sel)
            ADDR_MAX_LEASE: cfg_ff.lease_limit_ms <= csr_pwdata;
            ADDR_MAX_TTL: cfg_ff.ttl_limit_ms <= csr_pwdata;
            ADDR_VERIFIED: cfg_ff.params_verified <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         ADDR_MAX_LEASE: csr_prdata = cfg_ff.lease_limit_ms;
         ADDR_MAX_TTL: csr_prdata = cfg_ff.ttl_limit_ms;
         ADDR_VERIFIED: csr_prdata = {31'd0, cfg_ff.params_verified};
         default: csr_prdata = 32'd0;
      endcase
   end

endmodule
